### design/wbf_pkg.sv
`default_nettype none

package wbf_pkg;

   // default parameter values
   localparam int TABLE_DEPTH_DEF    = 1024;
   localparam int BUF_ENTRIES_DEF    = 32;
   localparam int AMP_FULL_SCALE_DEF = 4095;

   // field and register widths
   localparam int CMD_W      = 2;
   localparam int ADDR_W     = 10;
   localparam int DATA_W     = 16;
   localparam int SAMPLE_W   = 12;
   localparam int AMP_W      = 12;
   localparam int MODE_W     = 2;
   localparam int STEP_W     = 3;
   localparam int TSIZE_W    = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // scaling datapath
   localparam int PROD_W  = DATA_W + AMP_W;
   localparam int RECIP_W = PROD_W + 1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hfff;

   // output queue
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_FILL  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_code_type;

   localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TRIG   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 2'd3;

   localparam logic [AMP_W-1:0]   AMP_RESET   = 12'd4095;
   localparam logic [MODE_W-1:0]  MODE_RESET  = 2'd0;
   localparam logic [STEP_W-1:0]  STEP_RESET  = 3'd1;
   localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd1024;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] table_addr;
      logic [DATA_W-1:0] table_data;
      logic              trigger_active;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
      logic                period_done;
   } rsp_type;

   typedef struct packed {
      logic wr_table;
      logic clr_flag;
      logic start;
      logic issue;
      logic last;
      logic reduce;
   } ctl_cmd_type;

   typedef struct packed {
      logic credit_ok;
      logic reducing;
   } ctl_status_type;

endpackage

`default_nettype wire

### design/wbf_fifo.sv
`default_nettype none

module wbf_fifo
   import wbf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire rsp_type              push_data,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output rsp_type                   out_data,
   output logic [OUT_CNT_W-1:0]      count
);

   rsp_type                entry_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   pop;

   assign out_valid = (cnt_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = cnt_ff;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### design/wbf_dpath.sv
`default_nettype none

module wbf_dpath
   import wbf_pkg::*;
#(
   parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
   parameter int AMP_FULL_SCALE = AMP_FULL_SCALE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire ctl_cmd_type           cmd,
   output ctl_status_type             status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int SIZE_W = IDX_W + 1;
   localparam int SUM_W  = IDX_W + 2;
   localparam int QP_W   = PROD_W + RECIP_W;
   // floor(p / full scale) == (p * RECIP) >> SHIFT for every p below 2**PROD_W
   localparam int SHIFT  = PROD_W + $clog2(AMP_FULL_SCALE);
   localparam longint unsigned RECIP_C =
      ((64'd1 << SHIFT) + 64'(AMP_FULL_SCALE) - 64'd1) / 64'(AMP_FULL_SCALE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_C);

   // configuration
   logic [AMP_W-1:0]   amp_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [TSIZE_W-1:0] tsize_ff;

   // oscillator state
   logic [SUM_W-1:0] idx_ff, idx_in;
   logic             flag_ff, flag_in;
   logic             reducing_ff, reducing_in;
   logic             trig_ff;

   logic [DATA_W-1:0] wave_mem [TABLE_DEPTH];

   // pipeline
   logic              v0_ff, v1_ff, v2_ff;
   logic              zero0_ff;
   logic              last0_ff, last1_ff, last2_ff;
   logic              flag0_ff, flag1_ff, flag2_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [QP_W-1:0]   qprod_ff;

   logic [SIZE_W-1:0]    size;
   logic [SUM_W-1:0]     size_x;
   logic [SUM_W-1:0]     sum;
   logic [SUM_W-1:0]     diff;
   logic [SUM_W-1:0]     red;
   logic                 wrap;
   logic                 single;
   logic                 stop;
   logic                 sample_flag;
   logic [31:0]          addr_ext;
   logic [QP_W-1:0]      q_full;
   logic [SAMPLE_W-1:0]  q_sat;
   rsp_type              push_data;
   logic [OUT_CNT_W-1:0] fifo_cnt;
   logic [OUT_CNT_W:0]   pending;

   always_comb begin
      if (32'(tsize_ff) > 32'(TABLE_DEPTH)) begin
         size = SIZE_W'(TABLE_DEPTH);
      end else begin
         size = SIZE_W'(tsize_ff);
      end
      size_x = SUM_W'(size);
      single = (mode_ff == MODE_SINGLE);
      stop   = (size == '0) || (single && flag_ff) || ((mode_ff == MODE_TRIG) && !trig_ff);
      sum    = idx_ff + SUM_W'(step_ff);
      wrap   = (sum >= size_x);
      diff   = sum - size_x;
      red    = idx_ff - size_x;
      sample_flag = stop ? flag_ff : (flag_ff || wrap);
      addr_ext    = 32'(req_data.table_addr);
   end

   always_comb begin
      idx_in      = idx_ff;
      flag_in     = flag_ff;
      reducing_in = reducing_ff;
      if (cmd.clr_flag) begin
         flag_in = 1'b0;
      end
      if (cmd.reduce) begin
         idx_in      = red;
         reducing_in = (red >= size_x);
      end else if (cmd.issue && !stop) begin
         if (wrap) begin
            flag_in     = 1'b1;
            idx_in      = single ? '0 : diff;
            reducing_in = !single && (diff >= size_x);
         end else begin
            idx_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff      <= AMP_RESET;
         mode_ff     <= MODE_RESET;
         step_ff     <= STEP_RESET;
         tsize_ff    <= TSIZE_RESET;
         idx_ff      <= '0;
         flag_ff     <= 1'b0;
         reducing_ff <= 1'b0;
         v0_ff       <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_AMPLITUDE:  amp_ff   <= csr_wdata[AMP_W-1:0];
               CSR_MODE:       mode_ff  <= csr_wdata[MODE_W-1:0];
               CSR_STEP_SIZE:  step_ff  <= csr_wdata[STEP_W-1:0];
               CSR_TABLE_SIZE: tsize_ff <= csr_wdata[TSIZE_W-1:0];
               default: ;
            endcase
         end
         idx_ff      <= idx_in;
         flag_ff     <= flag_in;
         reducing_ff <= reducing_in;
         v0_ff       <= cmd.issue;
         v1_ff       <= v0_ff;
         v2_ff       <= v1_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         trig_ff <= req_data.trigger_active;
      end
      if (cmd.wr_table && (addr_ext < 32'(TABLE_DEPTH))) begin
         wave_mem[addr_ext[IDX_W-1:0]] <= req_data.table_data;
      end
      rd_data_ff <= wave_mem[idx_ff[IDX_W-1:0]];
      zero0_ff   <= stop;
      last0_ff   <= cmd.last;
      flag0_ff   <= sample_flag;
      prod_ff    <= zero0_ff ? '0 : PROD_W'(rd_data_ff) * PROD_W'(amp_ff);
      last1_ff   <= last0_ff;
      flag1_ff   <= flag0_ff;
      qprod_ff   <= QP_W'(prod_ff) * QP_W'(RECIP);
      last2_ff   <= last1_ff;
      flag2_ff   <= flag1_ff;
   end

   always_comb begin
      q_full = qprod_ff >> SHIFT;
      if (q_full > QP_W'(SAMPLE_MAX)) begin
         q_sat = SAMPLE_MAX;
      end else begin
         q_sat = q_full[SAMPLE_W-1:0];
      end
      push_data.sample      = q_sat;
      push_data.last        = last2_ff;
      push_data.period_done = flag2_ff;
   end

   wbf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (v2_ff),
      .push_data (push_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data),
      .count     (fifo_cnt)
   );

   // reserve a queue slot for every request in flight
   always_comb begin
      pending = {1'b0, fifo_cnt} + (OUT_CNT_W+1)'(v0_ff) + (OUT_CNT_W+1)'(v1_ff)
              + (OUT_CNT_W+1)'(v2_ff);
      status.credit_ok = (pending < (OUT_CNT_W+1)'(OUT_DEPTH));
      status.reducing  = reducing_ff;
   end

endmodule

`default_nettype wire

### design/wbf_ctrl.sv
`default_nettype none

module wbf_ctrl
   import wbf_pkg::*;
#(
   parameter int BUF_ENTRIES = BUF_ENTRIES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [CMD_W-1:0] req_command,
   output logic                  req_stall,
   input  wire ctl_status_type   status,
   output ctl_cmd_type           cmd
);

   localparam int CNT_W = $clog2(BUF_ENTRIES + 1);

   typedef enum logic {
      ST_IDLE,
      ST_FILL
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_WRITE: cmd.wr_table = 1'b1;
                  CMD_CLEAR: cmd.clr_flag = 1'b1;
                  CMD_FILL: begin
                     cmd.start = 1'b1;
                     cnt_in    = '0;
                     state_in  = ST_FILL;
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            // finish a modulo wrap before the next sample
            if (status.reducing) begin
               cmd.reduce = 1'b1;
            end else if (cnt_ff == CNT_W'(BUF_ENTRIES)) begin
               state_in = ST_IDLE;
            end else if (status.credit_ok) begin
               cmd.issue = 1'b1;
               cmd.last  = (cnt_ff == CNT_W'(BUF_ENTRIES - 1));
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### design/wavetable_buffer_filler_unit.sv
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_data: command, table_addr, table_data,
//                                        trigger_active
// rsp      out        rsp_valid/stall    rsp_data: sample, last, period_done
// csr      in         csr_we             csr_index, csr_wdata (write only)
//
// A table write or flag clear is accepted without a stall. A fill holds
// req_stall after its accept until the controller has issued BUF_ENTRIES samples
// and gone back to idle: one sample per cycle leaves the controller while the
// queue has credit, and issue pauses for each further subtract of a modulo wrap.
// Samples reach rsp through the table read, gain multiply, reciprocal
// multiply and queue write registers and an 8-entry queue; issue pauses when
// the queue has no free slot. Reset is synchronous: it clears state, index,
// flag and valid bits and loads the CSR reset values, but not the table.
`default_nettype none

module wavetable_buffer_filler_unit
   import wbf_pkg::*;
#(
   parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
   parameter int BUF_ENTRIES    = BUF_ENTRIES_DEF,
   parameter int AMP_FULL_SCALE = AMP_FULL_SCALE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   wbf_ctrl #(
      .BUF_ENTRIES (BUF_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   wbf_dpath #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .AMP_FULL_SCALE (AMP_FULL_SCALE)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### dv/tb_wavetable_buffer_filler_unit.sv
`timescale 1ns / 100ps

module tb_wavetable_buffer_filler_unit;
   import wbf_pkg::*;

   localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
   localparam logic [MODE_W-1:0] MODE_CONT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 16;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LOADED_ENTRIES   = 128;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   wavetable_buffer_filler_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // oscillator shadow state and register copies
   bit [DATA_W-1:0]  osc_table [0:TABLE_DEPTH_DEF-1];
   int unsigned      osc_index = 0;
   bit               osc_period_flag = 1'b0;
   bit [AMP_W-1:0]   cfg_amplitude = AMP_RESET;
   bit [MODE_W-1:0]  cfg_mode = MODE_RESET;
   bit [STEP_W-1:0]  cfg_step = STEP_RESET;
   bit [TSIZE_W-1:0] cfg_table_size = TSIZE_RESET;

   req_type     pending_reqs [$];
   rsp_type     expected_samples [$];
   int unsigned error_count = 0;

   bit          send_idle_en = 1'b0;
   bit          recv_idle_en = 1'b0;
   bit          hold_armed = 1'b0;
   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   int unsigned long_hold_cnt = 0;
   bit          long_hold_done = 1'b0;

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   function automatic void predict_buffer(input req_type r);
      int unsigned size, idx, raw, scaled;
      bit          running;
      rsp_type     s;
      if (r.command == CMD_WRITE) begin
         osc_table[r.table_addr] = r.table_data;
      end else if (r.command == CMD_CLEAR) begin
         osc_period_flag = 1'b0;
      end else if (r.command == CMD_FILL) begin
         running = 1'b1;
         size = (32'(cfg_table_size) > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF
                                                        : 32'(cfg_table_size);
         for (int k = 0; k < BUF_ENTRIES_DEF; k++) begin
            scaled = 0;
            if (size == 0 || (cfg_mode == MODE_SINGLE && osc_period_flag) ||
                (cfg_mode == MODE_TRIG && !r.trigger_active))
               running = 1'b0;
            if (running) begin
               idx = (osc_index >= TABLE_DEPTH_DEF) ? 0 : osc_index;
               raw = 32'(osc_table[idx]);
               scaled = raw * 32'(cfg_amplitude) / AMP_FULL_SCALE_DEF;
               if (scaled > 32'(SAMPLE_MAX)) scaled = 32'(SAMPLE_MAX);
               idx += 32'(cfg_step);
               if (idx >= size) begin
                  idx = (cfg_mode == MODE_SINGLE) ? 0 : idx % size;
                  osc_period_flag = 1'b1;
               end
               osc_index = idx;
            end
            s.sample      = scaled[SAMPLE_W-1:0];
            s.last        = (k == BUF_ENTRIES_DEF - 1);
            s.period_done = osc_period_flag;
            expected_samples.push_back(s);
         end
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && !req_stall) predict_buffer(req_data);
         // hold a stalled request as it is
         if (!(req_valid && req_stall)) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               send_wait <= send_idle_en ? $urandom_range(0, 4) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // sample monitor and receiver stall
   always @(posedge clock) begin
      rsp_type     want;
      int unsigned draw;
      if (reset) begin
         rsp_stall     <= 1'b0;
         recv_wait     <= 0;
         long_hold_cnt <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               flag_error($sformatf("unexpected sample %0d last %0b done %0b",
                  rsp_data.sample, rsp_data.last, rsp_data.period_done));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.sample !== want.sample || rsp_data.last !== want.last ||
                   rsp_data.period_done !== want.period_done)
                  flag_error($sformatf(
                     "sample exp %0d/last %0b/done %0b, got %0d/last %0b/done %0b",
                     want.sample, want.last, want.period_done,
                     rsp_data.sample, rsp_data.last, rsp_data.period_done));
            end
         end
         if (long_hold_cnt != 0) begin
            long_hold_cnt <= long_hold_cnt - 1;
            rsp_stall     <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            if (hold_armed && !long_hold_done) begin
               // back up the output queue until the block stalls its input
               long_hold_cnt  <= LONG_HOLD_CYCLES;
               long_hold_done <= 1'b1;
               rsp_stall      <= 1'b1;
            end else begin
               draw = recv_idle_en ? $urandom_range(0, 4) : 0;
               recv_wait <= (draw == 0) ? 0 : draw - 1;
               rsp_stall <= (draw != 0);
            end
         end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_req(input logic [CMD_W-1:0] cmd, input int unsigned addr,
                            input int unsigned data, input int unsigned trig);
      req_type r;
      r.command        = cmd;
      r.table_addr     = ADDR_W'(addr);
      r.table_data     = DATA_W'(data);
      r.trigger_active = trig[0];
      pending_reqs.push_back(r);
   endtask

   // wait until every request is taken and every sample is back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_samples.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'($urandom);
      case (idx)
         CSR_AMPLITUDE: begin
            word = CSR_DATA_W'(value);
            cfg_amplitude = AMP_W'(value);
         end
         CSR_MODE: begin
            word[MODE_W-1:0] = MODE_W'(value);
            cfg_mode = MODE_W'(value);
         end
         CSR_STEP_SIZE: begin
            word[STEP_W-1:0] = STEP_W'(value);
            cfg_step = STEP_W'(value);
         end
         CSR_TABLE_SIZE: begin
            word[TSIZE_W-1:0] = TSIZE_W'(value);
            cfg_table_size = TSIZE_W'(value);
         end
         default: ;
      endcase
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input int unsigned amp, input logic [MODE_W-1:0] mode,
                             input int unsigned step, input int unsigned size);
      wait_idle();
      write_register(CSR_AMPLITUDE, amp);
      write_register(CSR_MODE, 32'(mode));
      write_register(CSR_STEP_SIZE, step);
      write_register(CSR_TABLE_SIZE, size);
   endtask

   initial begin
      int unsigned         amp, step_v, size_v, pick;
      logic [MODE_W-1:0]   mode_v;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // load the low entries; every fill below stays inside them
      send_idle_en = 1'b1;
      recv_idle_en = 1'b1;
      for (int a = 0; a < LOADED_ENTRIES; a++)
         queue_req(CMD_WRITE, a, $urandom, $urandom);
      wait_idle();

      // reset settings: full gain, continuous, unit step, whole table
      queue_req(CMD_WRITE, 0, 'hffff, 1);
      queue_req(CMD_WRITE, 'h3ff, 'hffff, 0);
      queue_req(CMD_WRITE, 2, 0, 1);
      queue_req(CMD_FILL, 'h3ff, 'hffff, 0);
      queue_req(CMD_UNUSED, $urandom, $urandom, 1);
      queue_req(CMD_CLEAR, $urandom, $urandom, 0);
      queue_req(CMD_FILL, 0, 0, 1);

      // empty table and zero gain give silence
      set_config(0, MODE_CONT, 1, 0);
      queue_req(CMD_FILL, $urandom, $urandom, 1);

      // single period stops after the wrap until the flag is cleared
      set_config(4095, MODE_SINGLE, 4, 16);
      queue_req(CMD_FILL, $urandom, $urandom, 1);
      queue_req(CMD_FILL, $urandom, $urandom, 1);
      queue_req(CMD_CLEAR, $urandom, $urandom, 1);
      queue_req(CMD_FILL, $urandom, $urandom, 0);

      set_config(4095, MODE_TRIG, 1, 1024);
      queue_req(CMD_FILL, $urandom, $urandom, 1);
      queue_req(CMD_FILL, $urandom, $urandom, 0);

      // zero step holds the index
      set_config(2048, MODE_CONT, 0, 1024);
      queue_req(CMD_FILL, $urandom, $urandom, 0);

      // unused mode and an oversized table, leaving the index far out
      set_config(2048, MODE_UNUSED, 2, 2047);
      queue_req(CMD_FILL, $urandom, $urandom, 1);

      // shrink the table under the index, widest step
      set_config(300, MODE_CONT, 7, 20);
      queue_req(CMD_FILL, $urandom, $urandom, 1);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         pick = $urandom_range(0, 5);
         amp = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(0, 4095);
         pick = $urandom_range(0, 7);
         mode_v = (pick < 3) ? MODE_CONT : (pick < 5) ? MODE_SINGLE :
                  (pick < 7) ? MODE_TRIG : MODE_UNUSED;
         pick = $urandom_range(0, 9);
         step_v = (pick < 8) ? $urandom_range(1, 4) : (pick == 8) ? 0 : $urandom_range(5, 7);
         pick = $urandom_range(0, 9);
         case (pick)
            0:          size_v = 0;
            1, 2, 3, 4: size_v = $urandom_range(1, 64);
            5, 6:       size_v = LOADED_ENTRIES;
            default:    size_v = $urandom_range(65, LOADED_ENTRIES - 1);
         endcase
         set_config(amp, mode_v, step_v, size_v);
         // first phase runs without idling on either side
         send_idle_en = (p != 0);
         recv_idle_en = (p != 0);
         hold_armed   = (p == 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 5 && n == ITEMS_PER_PHASE / 2) wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 55)
               queue_req(CMD_FILL, $urandom, $urandom,
                         (mode_v == MODE_TRIG) ? 32'($urandom_range(0, 3) != 0)
                                               : $urandom);
            else if (pick < 80)
               queue_req(CMD_WRITE, $urandom, $urandom, $urandom);
            else if (pick < 95)
               queue_req(CMD_CLEAR, $urandom, $urandom, $urandom);
            else
               queue_req(CMD_UNUSED, $urandom, $urandom, $urandom);
         end
      end

      wait_idle();
      repeat (40) @(negedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### wavetable_buffer_filler_unit.f
design/wbf_pkg.sv
design/wbf_fifo.sv
design/wbf_dpath.sv
design/wbf_ctrl.sv
design/wavetable_buffer_filler_unit.sv
dv/tb_wavetable_buffer_filler_unit.sv
